// ===== design/cdd_pkg.sv =====
// Package for the capability descriptor decoder: result kinds, field
// constants and the structs shared by the decode stage and the top level.
// No dependencies.
package cdd_pkg;

   // Result kinds: one per decoded descriptor type, two for the I/O mapping, plus KIND_IGNORED
   typedef enum logic [3:0] {
      KIND_IGNORED   = 4'd0,
      KIND_KERNFLAGS = 4'd1,
      KIND_SVCMASK   = 4'd2,
      KIND_MAPFIRST  = 4'd3,
      KIND_MAPREGION = 4'd4,
      KIND_PAGE      = 4'd5,
      KIND_IRQ       = 4'd6,
      KIND_APPTYPE   = 4'd7,
      KIND_VERSION   = 4'd8,
      KIND_HANDLES   = 4'd9,
      KIND_DEBUG     = 4'd10
   } kind_type;

   localparam int DESC_W        = 32;
   localparam int WIDE_W        = 36;
   localparam int CODE_W        = 10;
   localparam int PRIO_W        = 6;
   localparam int CPU_W         = 8;
   localparam int PAGE_SHIFT    = 12;
   localparam int SVC_GROUP_W   = 3;

   // Syscall table entries covered by one mask group
   localparam int SVC_GROUP_SIZE    = 24;
   localparam int SVC_COUNT_DEFAULT = 128;

   localparam logic [WIDE_W-1:0] PAGE_BYTES = 36'h1000;

   // Pending first half of an I/O mapping
   typedef struct packed {
      logic              pending;
      logic [WIDE_W-1:0] address;
      logic              read_only;
   } map_state_type;

   // One input beat
   typedef struct packed {
      logic [DESC_W-1:0] descriptor;
      logic              list_start;
   } req_type;

   // One result beat
   typedef struct packed {
      kind_type          kind;
      logic [WIDE_W-1:0] wide_value;
      logic [WIDE_W-1:0] region_size;
      logic              flag_one;
      logic              flag_two;
      logic [PRIO_W-1:0] prio_high;
      logic [PRIO_W-1:0] prio_low;
      logic [CPU_W-1:0]  cpu_low;
      logic [CPU_W-1:0]  cpu_high;
      logic [CODE_W-1:0] code_one;
      logic [CODE_W-1:0] code_two;
      logic              svc_overflow;
   } rsp_type;

endpackage

// ===== design/cdd_req_if.sv =====
// Input channel of the capability descriptor decoder: valid/ready plus one
// descriptor word per beat. Depends on cdd_pkg.
interface cdd_req_if;
   import cdd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DESC_W-1:0] descriptor;
   logic              list_start;

   modport source (output valid, output descriptor, output list_start, input ready);
   modport sink   (input valid, input descriptor, input list_start, output ready);
endinterface

// ===== design/cdd_rsp_if.sv =====
// Result channel of the capability descriptor decoder: valid/ready plus the
// decoded fields of one descriptor per beat. Depends on cdd_pkg.
interface cdd_rsp_if;
   import cdd_pkg::*;

   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [WIDE_W-1:0] wide_value;
   logic [WIDE_W-1:0] region_size;
   logic              flag_one;
   logic              flag_two;
   logic [PRIO_W-1:0] prio_high;
   logic [PRIO_W-1:0] prio_low;
   logic [CPU_W-1:0]  cpu_low;
   logic [CPU_W-1:0]  cpu_high;
   logic [CODE_W-1:0] code_one;
   logic [CODE_W-1:0] code_two;
   logic              svc_overflow;

   modport source (
      output valid, output kind, output wide_value, output region_size,
      output flag_one, output flag_two, output prio_high, output prio_low,
      output cpu_low, output cpu_high, output code_one, output code_two,
      output svc_overflow, input ready
   );
   modport sink (
      input valid, input kind, input wide_value, input region_size,
      input flag_one, input flag_two, input prio_high, input prio_low,
      input cpu_low, input cpu_high, input code_one, input code_two,
      input svc_overflow, output ready
   );
endinterface

// ===== design/cdd_decode.sv =====
// Combinational decode of one registered descriptor word into a result beat
// and the next pending-mapping state. Depends on cdd_pkg.
module cdd_decode #(
   parameter int SVC_COUNT = cdd_pkg::SVC_COUNT_DEFAULT
) (
   input  cdd_pkg::req_type       req,
   input  cdd_pkg::map_state_type map_state,
   output cdd_pkg::rsp_type       rsp,
   output cdd_pkg::map_state_type map_next
);
   import cdd_pkg::*;

   // Compare width: wide enough for the table size and for 8 groups of 24
   localparam int SvcCntW = $clog2(SVC_COUNT + 1);
   localparam int CmpW    = (SvcCntW > 8) ? SvcCntW : 8;

   logic [DESC_W-1:0]      word;
   logic                   pend;
   logic [SVC_GROUP_W-1:0] svc_group;
   logic [SVC_GROUP_W:0]   group_count;
   logic [CmpW-1:0]        svc_reach;
   logic [WIDE_W-1:0]      map_value;

   assign word        = req.descriptor;
   // list start drops a half-open mapping before this word is decoded
   assign pend        = map_state.pending & ~req.list_start;
   assign svc_group   = word[31:29];
   assign group_count = {1'b0, svc_group} + (SVC_GROUP_W+1)'(1);
   assign svc_reach   = CmpW'(group_count) * CmpW'(SVC_GROUP_SIZE);
   assign map_value   = {word[30:7], {PAGE_SHIFT{1'b0}}};

   // Type select by count of trailing ones; payload starts above the first zero
   always_comb begin
      rsp              = '0;
      rsp.kind         = KIND_IGNORED;
      map_next         = map_state;
      map_next.pending = pend;
      case (word[16:0]) inside
         17'b????_????_????_?_0111: begin
            rsp.kind      = KIND_KERNFLAGS;
            rsp.prio_high = word[9:4];
            rsp.prio_low  = word[15:10];
            rsp.cpu_low   = word[23:16];
            rsp.cpu_high  = word[31:24];
         end
         17'b????_????_????_0_1111: begin
            rsp.kind         = KIND_SVCMASK;
            rsp.wide_value   = WIDE_W'(word[28:5]);
            rsp.code_one     = CODE_W'(svc_group);
            rsp.svc_overflow = (svc_reach > CmpW'(SVC_COUNT));
         end
         17'b????_????_??_0_11_1111: begin
            if (!pend) begin
               rsp.kind           = KIND_MAPFIRST;
               rsp.wide_value     = map_value;
               rsp.flag_one       = word[31];
               map_next.pending   = 1'b1;
               map_next.address   = map_value;
               map_next.read_only = word[31];
            end else begin
               rsp.kind         = KIND_MAPREGION;
               rsp.wide_value   = map_state.address;
               rsp.region_size  = map_value;
               rsp.flag_one     = map_state.read_only;
               rsp.flag_two     = word[31];
               map_next.pending = 1'b0;
            end
         end
         17'b????_????_?_0_111_1111: begin
            rsp.kind        = KIND_PAGE;
            rsp.wide_value  = {word[31:8], {PAGE_SHIFT{1'b0}}};
            rsp.region_size = PAGE_BYTES;
         end
         17'b????_?_0_111_1111_1111: begin
            rsp.kind     = KIND_IRQ;
            rsp.code_one = word[21:12];
            rsp.code_two = word[31:22];
         end
         17'b???_0_1_1111_1111_1111: begin
            rsp.kind     = KIND_APPTYPE;
            rsp.code_one = CODE_W'(word[16:14]);
         end
         17'b??_0_11_1111_1111_1111: begin
            rsp.kind       = KIND_VERSION;
            rsp.wide_value = WIDE_W'(word[31:15]);
         end
         17'b?_0_111_1111_1111_1111: begin
            rsp.kind       = KIND_HANDLES;
            rsp.wide_value = WIDE_W'(word[31:16]);
         end
         17'b0_1111_1111_1111_1111: begin
            rsp.kind     = KIND_DEBUG;
            rsp.flag_one = word[17];
            rsp.flag_two = word[18];
         end
         default: begin
            rsp.kind = KIND_IGNORED;
         end
      endcase
   end

endmodule

// ===== design/cdd_map_hold.sv =====
// Holding register for the first half of a two-word I/O mapping.
// Depends on cdd_pkg.
module cdd_map_hold (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  cdd_pkg::map_state_type map_next,
   output cdd_pkg::map_state_type map_state
);
   import cdd_pkg::*;

   map_state_type map_ff;
   map_state_type map_in;

   // Take the decoder's next state when a beat moves to the result register
   assign map_in = update ? map_next : map_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else begin
         map_ff <= map_in;
      end
   end

   assign map_state = map_ff;

   // A fresh first half must show the pending flag right after
   assert property (@(posedge clock) disable iff (reset)
      update && !map_ff.pending && map_next.pending |=> map_ff.pending)
      else $error("mapping half not held");

   // Without an update the held half never changes
   assert property (@(posedge clock) disable iff (reset)
      !update |=> $stable(map_ff))
      else $error("held mapping changed without a beat");

   // Completing a mapping always frees the holding register
   assert property (@(posedge clock) disable iff (reset)
      update && map_ff.pending && !map_next.pending |=> !map_ff.pending)
      else $error("mapping still pending after completion");

endmodule

// ===== design/capability_descriptor_decoder.sv =====
// Top level of the capability descriptor decoder: input register, decode,
// result register. Depends on cdd_pkg, cdd_req_if, cdd_rsp_if, cdd_decode
// and cdd_map_hold.
//
//   channel   | dir | beat contents
//   ----------+-----+------------------------------------------------------
//   req_chan  | in  | descriptor word, list_start
//   rsp_chan  | out | kind and decoded fields, one beat per descriptor
//
// A result passes the input register and then the result register, and is valid
// on rsp_chan once it sits in the result register. One descriptor per cycle is
// sustained while rsp_chan.ready stays high; the decode between the two
// registers is a fixed-slice select.
// Reset is synchronous and clears both valid bits and the pending mapping.
// A stalled result holds the result register, then the input register, and
// only then drops req_chan.ready.
module capability_descriptor_decoder #(
   parameter int SVC_COUNT = cdd_pkg::SVC_COUNT_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   cdd_req_if.sink  req_chan,
   cdd_rsp_if.source rsp_chan
);
   import cdd_pkg::*;

   logic          in_valid_ff, in_valid_in;
   req_type       in_data_ff, in_data_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff, out_data_in;

   logic          out_free;
   logic          in_free;
   logic          advance;
   rsp_type       dec_rsp;
   map_state_type map_state;
   map_state_type map_next;

   // Stall chain: each stage frees up when empty or when it drains
   assign out_free       = ~out_valid_ff | rsp_chan.ready;
   assign in_free        = ~in_valid_ff | out_free;
   assign advance        = in_valid_ff & out_free;
   assign req_chan.ready = in_free;

   // Input register
   assign in_valid_in = in_free ? req_chan.valid : in_valid_ff;
   always_comb begin
      in_data_in = in_data_ff;
      if (in_free && req_chan.valid) begin
         in_data_in.descriptor = req_chan.descriptor;
         in_data_in.list_start = req_chan.list_start;
      end
   end

   cdd_decode #(
      .SVC_COUNT (SVC_COUNT)
   ) u_decode (
      .req       (in_data_ff),
      .map_state (map_state),
      .rsp       (dec_rsp),
      .map_next  (map_next)
   );

   cdd_map_hold u_map_hold (
      .clock     (clock),
      .reset     (reset),
      .update    (advance),
      .map_next  (map_next),
      .map_state (map_state)
   );

   // Result register
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;
   assign out_data_in  = advance ? dec_rsp : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_data_ff.kind;
   assign rsp_chan.wide_value   = out_data_ff.wide_value;
   assign rsp_chan.region_size  = out_data_ff.region_size;
   assign rsp_chan.flag_one     = out_data_ff.flag_one;
   assign rsp_chan.flag_two     = out_data_ff.flag_two;
   assign rsp_chan.prio_high    = out_data_ff.prio_high;
   assign rsp_chan.prio_low     = out_data_ff.prio_low;
   assign rsp_chan.cpu_low      = out_data_ff.cpu_low;
   assign rsp_chan.cpu_high     = out_data_ff.cpu_high;
   assign rsp_chan.code_one     = out_data_ff.code_one;
   assign rsp_chan.code_two     = out_data_ff.code_two;
   assign rsp_chan.svc_overflow = out_data_ff.svc_overflow;

   // A beat in the input register waits while the result register is stuck
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_data_ff))
      else $error("input beat lost during stall");

   // A first mapping half leaves its address in the holding register
   assert property (@(posedge clock) disable iff (reset)
      advance && dec_rsp.kind == KIND_MAPFIRST
      |=> map_state.pending && map_state.address == out_data_ff.wide_value)
      else $error("mapping address not held");

   // A completed mapping reports the held address
   assert property (@(posedge clock) disable iff (reset)
      advance && dec_rsp.kind == KIND_MAPREGION |-> dec_rsp.wide_value == map_state.address)
      else $error("mapping region lost its address");

   // Every beat that leaves the input register lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("decoded beat dropped");

endmodule
